// ===== rtl/ddd_pkg.sv =====
package ddd_pkg;

   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int MP_W        = 4;
   localparam int DAYNUM_W    = 22;
   localparam int DIFF_W      = 23;
   localparam int MOFF_W      = 9;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   localparam int YEAR_MAX    = 9999;
   localparam int DAYS_YEAR   = 365;

   localparam int Q100_MUL    = 5243;
   localparam int Q100_MUL_W  = 13;
   localparam int Q100_SHIFT  = 19;
   localparam int PROD_W      = YEAR_W + Q100_MUL_W;
   localparam int QUOT_W      = PROD_W - Q100_SHIFT;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [MP_W-1:0]   mp;
      logic [YEAR_W-1:0] yy;
   } date_type;

   typedef struct packed {
      date_type first;
      date_type second;
      logic     incl;
      logic     err;
   } entry_type;

   function automatic logic [QUOT_W-1:0] quot100(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] p;
      p = PROD_W'(y) * PROD_W'(Q100_MUL);
      return p[PROD_W-1:Q100_SHIFT];
   endfunction

   function automatic logic [MOFF_W-1:0] month_offset(input logic [MP_W-1:0] mp);
      logic [MOFF_W-1:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/date_day_difference.sv =====
// Signed day count between two Gregorian dates (4/100/400 leap rule), from the
// first date to the second, one result word per request word. A new date pair
// is taken every cycle while the queue has room, as every stage of the
// closed-form day-number arithmetic takes one word per cycle unless the result
// side stalls; a request word passes the front register, the queue and the
// back's three stages on its way to the outputs. With the include flag set
// the magnitude grows by one (equal dates give +1). A date with day zero, a
// day beyond its month, a bad month or a year outside 1..9999 raises
// rsp_tuser and returns zero. A short queue between the checking front and
// the arithmetic back keeps requests flowing while the result side stalls.
module date_day_difference #(
   parameter int QUEUE_DEPTH = ddd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_day, first_month, first_year, second_day, second_month,
   // second_year, include_end_day, zero fill
   input  logic [ddd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // day_difference, zero fill
   output logic [ddd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // date_error
   output logic                           rsp_tuser
);
   import ddd_pkg::*;

   logic                     push_valid, push_ready;
   logic                     pop_valid, pop_ready;
   entry_type                push_entry, pop_entry;
   logic signed [DIFF_W-1:0] diff;

   ddd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   ddd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ddd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_diff  (diff),
      .rsp_err   (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - DIFF_W){1'b0}}, diff};

endmodule

// ===== rtl/ddd_front.sv =====
module ddd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ddd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             push_valid,
   input  logic                             push_ready,
   output ddd_pkg::entry_type               push_entry
);
   import ddd_pkg::*;

   logic                  valid_ff, valid_in;
   logic [REQ_DATA_W-1:0] data_ff;
   logic [QUOT_W-1:0]     q1_ff, q2_ff;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (m) inside
         4'd2:                               r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:            r = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         default:                            r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0] y,
                                    input logic [QUOT_W-1:0] q);
      logic [YEAR_W-1:0] qx;
      logic [YEAR_W-1:0] rem;
      logic              leap;
      qx   = YEAR_W'(q);
      rem  = y - ((qx << 6) + (qx << 5) + (qx << 2));
      leap = ((y[1:0] == 2'd0) && (rem != '0)) || ((rem == '0) && (q[1:0] == 2'd0));
      return (y != '0) && (y <= YEAR_W'(YEAR_MAX)) && (d != '0) && (d <= month_len(m, leap));
   endfunction

   function automatic date_type shift_date(input logic [DAY_W-1:0] d,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [YEAR_W-1:0] y);
      date_type r;
      r.day = d;
      if (m <= 4'd2) begin
         r.mp = m + 4'd9;
         r.yy = y - 14'd1;
      end else begin
         r.mp = m - 4'd3;
         r.yy = y;
      end
      return r;
   endfunction

   logic [DAY_W-1:0]   d1, d2;
   logic [MONTH_W-1:0] m1, m2;
   logic [YEAR_W-1:0]  y1, y2;

   assign d1 = data_ff[4:0];
   assign m1 = data_ff[8:5];
   assign y1 = data_ff[22:9];
   assign d2 = data_ff[27:23];
   assign m2 = data_ff[31:28];
   assign y2 = data_ff[45:32];

   assign req_tready = !valid_ff || push_ready;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;
   assign push_valid = valid_ff;

   always_comb begin
      push_entry.first  = shift_date(d1, m1, y1);
      push_entry.second = shift_date(d2, m2, y2);
      push_entry.incl   = data_ff[46];
      push_entry.err    = !date_ok(d1, m1, y1, q1_ff) || !date_ok(d2, m2, y2, q2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         data_ff <= req_tdata;
         q1_ff   <= quot100(req_tdata[22:9]);
         q2_ff   <= quot100(req_tdata[45:32]);
      end
   end

endmodule

// ===== rtl/ddd_queue.sv =====
module ddd_queue #(
   parameter int DEPTH = ddd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ddd_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ddd_pkg::entry_type pop_entry
);
   import ddd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/ddd_back.sv =====
module ddd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  ddd_pkg::entry_type               pop_entry,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [ddd_pkg::DIFF_W-1:0] rsp_diff,
   output logic                             rsp_err
);
   import ddd_pkg::*;

   typedef struct packed {
      logic [DAYNUM_W-1:0] mul365;
      logic [YEAR_W-3:0]   y4;
      logic [QUOT_W-1:0]   q100;
      logic [MOFF_W-1:0]   moff;
   } part_type;

   function automatic part_type split_date(input date_type dt);
      part_type r;
      r.mul365 = DAYNUM_W'(dt.yy) * DAYNUM_W'(DAYS_YEAR);
      r.y4     = dt.yy[YEAR_W-1:2];
      r.q100   = quot100(dt.yy);
      r.moff   = month_offset(dt.mp) + MOFF_W'(dt.day) - 1'b1;
      return r;
   endfunction

   function automatic logic [DAYNUM_W-1:0] day_number(input part_type p);
      return p.mul365 + DAYNUM_W'(p.y4) - DAYNUM_W'(p.q100)
             + DAYNUM_W'(p.q100 >> 2) + DAYNUM_W'(p.moff);
   endfunction

   logic                enable;
   logic                s1_valid_ff, s2_valid_ff, out_valid_ff;
   part_type            s1_a_ff, s1_b_ff;
   logic                s1_incl_ff, s1_err_ff;
   logic [DAYNUM_W-1:0] s2_n1_ff, s2_n2_ff;
   logic                s2_incl_ff, s2_err_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                err_ff;

   assign enable    = !out_valid_ff || rsp_ready;
   assign pop_ready = enable;

   always_comb begin
      logic signed [DIFF_W-1:0] raw;
      raw = DIFF_W'(s2_n2_ff) - DIFF_W'(s2_n1_ff);
      if (s2_err_ff) begin
         diff_in = '0;
      end else if (s2_incl_ff) begin
         diff_in = (s2_n2_ff >= s2_n1_ff) ? raw + DIFF_W'(1) : raw - DIFF_W'(1);
      end else begin
         diff_in = raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_a_ff    <= split_date(pop_entry.first);
         s1_b_ff    <= split_date(pop_entry.second);
         s1_incl_ff <= pop_entry.incl;
         s1_err_ff  <= pop_entry.err;
         s2_n1_ff   <= day_number(s1_a_ff);
         s2_n2_ff   <= day_number(s1_b_ff);
         s2_incl_ff <= s1_incl_ff;
         s2_err_ff  <= s1_err_ff;
         diff_ff    <= diff_in;
         err_ff     <= s2_err_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_diff  = diff_ff;
   assign rsp_err   = err_ff;

endmodule

// ===== tb/sv/date_day_difference_checker.sv =====
module date_day_difference_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // first_day, first_month, first_year, second_day, second_month,
   // second_year, include_end_day, zero fill
   input  logic [ddd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // day_difference, zero fill
   input  logic [ddd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // date_error
   input  logic                           rsp_tuser,
   output int                             mismatch_count,
   output int                             results_owed
);
   import ddd_pkg::*;

   localparam int M1_LO    = DAY_W;
   localparam int Y1_LO    = M1_LO + MONTH_W;
   localparam int D2_LO    = Y1_LO + YEAR_W;
   localparam int M2_LO    = D2_LO + DAY_W;
   localparam int Y2_LO    = M2_LO + MONTH_W;
   localparam int INCL_BIT = Y2_LO + YEAR_W;

   typedef struct packed {
      logic [DIFF_W-1:0] days;
      logic              bad;
   } span_type;

   span_type span_q[$];

   function automatic bit is_leap(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic bit date_valid(input int d, input int m, input int y);
      int last;
      if (m == 2) begin
         last = is_leap(y) ? 29 : 28;
      end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
         last = 30;
      end else if (m >= 1 && m <= 12) begin
         last = 31;
      end else begin
         last = 0;
      end
      return (y >= 1) && (y <= YEAR_MAX) && (d >= 1) && (d <= last);
   endfunction

   // days since the start of year 1, counting 1 January of year 1 as day 1
   function automatic int serial_day(input int d, input int m, input int y);
      int prior;
      int month_start;
      prior = y - 1;
      case (m)
         1:       month_start = 0;
         2:       month_start = 31;
         3:       month_start = 59;
         4:       month_start = 90;
         5:       month_start = 120;
         6:       month_start = 151;
         7:       month_start = 181;
         8:       month_start = 212;
         9:       month_start = 243;
         10:      month_start = 273;
         11:      month_start = 304;
         default: month_start = 334;
      endcase
      if (m > 2 && is_leap(y)) month_start = month_start + 1;
      return DAYS_YEAR * prior + prior / 4 - prior / 100 + prior / 400 + month_start + d;
   endfunction

   function automatic span_type span_between(input logic [REQ_DATA_W-1:0] w);
      int       d1, m1, y1, d2, m2, y2;
      int       gap;
      span_type s;
      d1 = int'(w[0 +: DAY_W]);
      m1 = int'(w[M1_LO +: MONTH_W]);
      y1 = int'(w[Y1_LO +: YEAR_W]);
      d2 = int'(w[D2_LO +: DAY_W]);
      m2 = int'(w[M2_LO +: MONTH_W]);
      y2 = int'(w[Y2_LO +: YEAR_W]);
      if (!date_valid(d1, m1, y1) || !date_valid(d2, m2, y2)) begin
         s.days = '0;
         s.bad  = 1'b1;
      end else begin
         gap = serial_day(d2, m2, y2) - serial_day(d1, m1, y1);
         if (w[INCL_BIT]) gap = (gap >= 0) ? gap + 1 : gap - 1;
         s.days = DIFF_W'(gap);
         s.bad  = 1'b0;
      end
      return s;
   endfunction

   always @(posedge clock) begin
      span_type want;
      int       slips;
      slips = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (span_q.size() == 0) begin
               $error("unexpected result word: day_difference %0d date_error %0b",
                      $signed(rsp_tdata[DIFF_W-1:0]), rsp_tuser);
               slips = slips + 1;
            end else begin
               want = span_q.pop_front();
               if (rsp_tdata[DIFF_W-1:0] !== want.days) begin
                  $error("day_difference: expected %0d, actual %0d",
                         $signed(want.days), $signed(rsp_tdata[DIFF_W-1:0]));
                  slips = slips + 1;
               end
               if (rsp_tuser !== want.bad) begin
                  $error("date_error: expected %0b, actual %0b", want.bad, rsp_tuser);
                  slips = slips + 1;
               end
            end
         end
         if (req_tvalid && req_tready) span_q.push_back(span_between(req_tdata));
      end
      mismatch_count <= mismatch_count + slips;
      results_owed   <= span_q.size();
   end

endmodule

// ===== tb/sv/date_day_difference_tb.sv =====
module date_day_difference_tb;
   import ddd_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int mismatch_count;
   int results_owed;
   int holds_asked = 0;
   bit calm        = 1'b0;

   date_day_difference u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   date_day_difference_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [REQ_DATA_W-1:0] date_pair(input int d1, input int m1,
                                                        input int y1, input int d2,
                                                        input int m2, input int y2,
                                                        input bit incl);
      return REQ_DATA_W'({incl, YEAR_W'(y2), MONTH_W'(m2), DAY_W'(d2),
                          YEAR_W'(y1), MONTH_W'(m1), DAY_W'(d1)});
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic offer(input logic [REQ_DATA_W-1:0] w);
      int g;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      g = idle_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic offer_random();
      int r, band, lo, hi;
      int y1, y2, d1, d2;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         offer(date_pair($urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 16383), $urandom_range(0, 31),
                         $urandom_range(0, 15), $urandom_range(0, 16383),
                         $urandom_range(0, 1)));
      end else begin
         band = $urandom_range(0, 9);
         lo   = (band == 2) ? 9940 : 1;
         hi   = (band < 2) ? 60 : YEAR_MAX;
         y1   = $urandom_range(lo, hi);
         if (r < 55) begin
            y2 = y1 + $urandom_range(0, 4) - 2;
            if (y2 < 1) y2 = 1;
            if (y2 > YEAR_MAX) y2 = YEAR_MAX;
         end else begin
            y2 = $urandom_range(lo, hi);
         end
         if (r < 22) begin
            d1 = $urandom_range(28, 31);
            d2 = $urandom_range(28, 31);
         end else begin
            d1 = $urandom_range(1, 28);
            d2 = $urandom_range(1, 28);
         end
         offer(date_pair(d1, $urandom_range(1, 12), y1, d2, $urandom_range(1, 12), y2,
                         $urandom_range(0, 1)));
      end
   endtask

   initial begin
      int g, holds_done;
      holds_done = 0;
      @(negedge reset);
      forever begin
         if (holds_done != holds_asked) begin
            holds_done = holds_done + 1;
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
         end else begin
            g = idle_len();
            if (g != 0) begin
               rsp_tready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(date_pair(1, 1, 1, 31, 12, YEAR_MAX, 1'b0));
      offer(date_pair(31, 12, YEAR_MAX, 1, 1, 1, 1'b1));
      offer(date_pair(15, 6, 2020, 15, 6, 2020, 1'b0));
      offer(date_pair(15, 6, 2020, 15, 6, 2020, 1'b1));
      offer(date_pair(29, 2, 2000, 1, 3, 2000, 1'b0));
      offer(date_pair(29, 2, 1900, 1, 3, 1900, 1'b0));
      offer(date_pair(29, 2, 2024, 28, 2, 2023, 1'b1));
      offer(date_pair(30, 2, 2024, 1, 3, 2024, 1'b0));
      offer(date_pair(1, 1, 2021, 31, 4, 2021, 1'b0));
      offer(date_pair(0, 5, 2010, 3, 5, 2010, 1'b0));
      offer(date_pair(3, 5, 2010, 3, 0, 2010, 1'b1));
      offer(date_pair(3, 13, 2010, 3, 5, 2010, 1'b0));
      offer(date_pair(31, 15, 2010, 3, 5, 2010, 1'b0));
      offer(date_pair(1, 1, 0, 1, 1, 1, 1'b0));
      offer(date_pair(1, 1, 1, 1, 1, 10000, 1'b0));
      offer(date_pair(1, 1, 1, 31, 12, 16383, 1'b1));
      offer(date_pair(31, 12, 1999, 1, 1, 2000, 1'b1));
      offer(date_pair(28, 2, 2100, 1, 3, 2100, 1'b0));
      offer(date_pair(31, 1, 2023, 31, 12, 2023, 1'b0));
      offer(date_pair(0, 0, 0, 0, 0, 0, 1'b1));
      offer(date_pair(31, 15, 16383, 31, 15, 16383, 1'b1));

      for (k = 0; k < 1900; k++) begin
         if (k % 100 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            if (k == 500) begin
               calm        = 1'b1;
               holds_asked = holds_asked + 1;
            end
            if (k == 1000) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait (results_owed == 0);
               @(posedge clock);
            end
         end
         offer_random();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
